### hw/rtl/i2csb_pkg.sv
// Package with the shared types and constants of the I2C slave buffer handler.
`timescale 1ns / 1ps
`default_nettype none

package i2csb_pkg;

    localparam int RX_DEPTH = 16;
    localparam int TX_DEPTH = 16;

    localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

    // The receive count runs 1..RX_DEPTH, the send count 1..TX_DEPTH+1.
    localparam int RXC_W = $clog2(RX_DEPTH + 1);
    localparam int TXC_W = $clog2(TX_DEPTH + 2);

    localparam logic [6:0] SLAVE_ADDR_RESET = 7'd120;

    typedef enum logic [2:0] {
        MODE_ADDR    = 3'd0,
        MODE_RX      = 3'd1,
        MODE_STOP    = 3'd2,
        MODE_SENT    = 3'd3,
        MODE_ERR     = 3'd4,
        MODE_HOST_WR = 3'd5,
        MODE_HOST_RD = 3'd6
    } mode_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] bus_byte;
        logic       arbitration_lost;
        logic       master_acked;
        logic [3:0] host_index;
        logic [7:0] host_byte;
    } in_item_t;

    typedef struct packed {
        logic       ack_drive;
        logic [7:0] tx_byte;
        logic       tx_loaded;
        logic       data_ready;
        logic [7:0] host_read_byte;
    } out_item_t;

    // Control carried from the accept stage to the memory-data stage.
    typedef struct packed {
        logic ack;
        logic load_mem;
        logic load_zero;
        logic host_read;
        logic ready;
    } stage_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/i2c_slave_buffer_handler_unit.sv
// Top level of the I2C slave buffer handler: event decode, counters and buffer RAMs.
`timescale 1ns / 1ps
`default_nettype none

//  Channel  Handshake              Payload
//  in       in_valid / in_ready    in_data   (i2csb_pkg::in_item_t)
//  out      out_valid / out_ready  out_data  (i2csb_pkg::out_item_t)
//  cfg      cfg_valid / cfg_ready  cfg_data  (slave address, 7 bits)
//
//  One item is accepted per cycle while the pipeline is not stalled; its result
//  is held in the data stage register and then in the output register.
//  The counters and the ready flag update at accept; the RAM
//  read issued then is registered in the RAM and sets the staged transmit byte.
//  Reset sets both counters to 1 and clears the flags and staged byte; the
//  buffers hold whatever they held until written. A stalled output holds
//  the pipeline, and the input stalls only when both stages are full.

module i2c_slave_buffer_handler_unit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire i2csb_pkg::in_item_t  in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output i2csb_pkg::out_item_t      out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [6:0]           cfg_data
);

    logic [6:0]                     slave_addr_reg;
    logic [i2csb_pkg::RXC_W-1:0]    recv_count_reg, recv_count_next;
    logic [i2csb_pkg::TXC_W-1:0]    send_count_reg, send_count_next;
    logic                           ready_flag_reg, ready_flag_next;
    logic [7:0]                     staged_tx_reg, staged_tx_next;

    logic                           s1_valid_reg;
    i2csb_pkg::stage_ctl_t          s1_ctl_reg, s1_ctl_next;
    logic                           out_valid_reg;
    i2csb_pkg::out_item_t           out_data_reg, out_data_next;

    logic                           in_fire;
    logic                           s1_adv;

    logic                           rx_we, rx_re, tx_we, tx_re;
    logic [i2csb_pkg::RX_AW-1:0]    rx_waddr, rx_raddr;
    logic [i2csb_pkg::TX_AW-1:0]    tx_waddr, tx_raddr;
    logic [7:0]                     rx_rdata, tx_rdata;

    assign cfg_ready = 1'b1;
    assign s1_adv    = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign in_fire   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= i2csb_pkg::SLAVE_ADDR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            slave_addr_reg <= cfg_data;
        end
    end

    // Accept stage: counters, flag, RAM writes and read requests.
    always_comb
    begin
        recv_count_next = recv_count_reg;
        send_count_next = send_count_reg;
        ready_flag_next = ready_flag_reg;
        s1_ctl_next     = '0;
        rx_we           = 1'b0;
        rx_re           = 1'b0;
        tx_we           = 1'b0;
        tx_re           = 1'b0;
        rx_waddr        = i2csb_pkg::RX_AW'(recv_count_reg - 1'b1);
        rx_raddr        = i2csb_pkg::RX_AW'(in_data.host_index);
        tx_waddr        = i2csb_pkg::TX_AW'(in_data.host_index);
        tx_raddr        = i2csb_pkg::TX_AW'(send_count_reg - 1'b1);
        if (in_fire)
        begin
            unique case (in_data.mode)
                i2csb_pkg::MODE_HOST_WR:
                begin
                    tx_we = 32'(in_data.host_index) < i2csb_pkg::TX_DEPTH;
                end
                i2csb_pkg::MODE_HOST_RD:
                begin
                    rx_re = 32'(in_data.host_index) < i2csb_pkg::RX_DEPTH;
                    s1_ctl_next.host_read = rx_re;
                end
                i2csb_pkg::MODE_ADDR:
                begin
                    if (!in_data.arbitration_lost)
                    begin
                        recv_count_next = i2csb_pkg::RXC_W'(1);
                        send_count_next = i2csb_pkg::TXC_W'(1);
                        if (in_data.bus_byte[7:1] == slave_addr_reg)
                        begin
                            s1_ctl_next.ack = 1'b1;
                            if (in_data.bus_byte[0])
                            begin
                                // A read addressing stages the first transmit byte.
                                send_count_next      = i2csb_pkg::TXC_W'(2);
                                tx_re                = 1'b1;
                                tx_raddr             = '0;
                                s1_ctl_next.load_mem = 1'b1;
                            end
                        end
                    end
                end
                i2csb_pkg::MODE_RX:
                begin
                    if (!in_data.arbitration_lost)
                    begin
                        rx_we           = 1'b1;
                        s1_ctl_next.ack = 1'b1;
                        if (32'(recv_count_reg) < i2csb_pkg::RX_DEPTH)
                        begin
                            recv_count_next = recv_count_reg + 1'b1;
                            ready_flag_next = 1'b0;
                        end
                        else
                        begin
                            ready_flag_next = 1'b1;
                        end
                    end
                end
                i2csb_pkg::MODE_SENT:
                begin
                    if (!in_data.arbitration_lost && in_data.master_acked)
                    begin
                        if (32'(send_count_reg) <= i2csb_pkg::TX_DEPTH)
                        begin
                            tx_re                = 1'b1;
                            send_count_next      = send_count_reg + 1'b1;
                            s1_ctl_next.load_mem = 1'b1;
                        end
                        else
                        begin
                            s1_ctl_next.load_zero = 1'b1;
                        end
                    end
                end
                default:
                begin
                    // Stop, bus error and unknown events change nothing.
                end
            endcase
        end
        s1_ctl_next.ready = ready_flag_next;
    end

    i2csb_ram #(
        .WIDTH (8),
        .DEPTH (i2csb_pkg::RX_DEPTH),
        .AW    (i2csb_pkg::RX_AW)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (in_data.bus_byte),
        .re    (rx_re),
        .raddr (rx_raddr),
        .rdata (rx_rdata)
    );

    i2csb_ram #(
        .WIDTH (8),
        .DEPTH (i2csb_pkg::TX_DEPTH),
        .AW    (i2csb_pkg::TX_AW)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_waddr),
        .wdata (in_data.host_byte),
        .re    (tx_re),
        .raddr (tx_raddr),
        .rdata (tx_rdata)
    );

    // Data stage: the RAM read data is held while this stage stalls,
    // since no new read is issued until the item moves on.
    always_comb
    begin
        staged_tx_next = staged_tx_reg;
        if (s1_ctl_reg.load_mem)
        begin
            staged_tx_next = tx_rdata;
        end
        else if (s1_ctl_reg.load_zero)
        begin
            staged_tx_next = 8'h00;
        end
        out_data_next.ack_drive      = s1_ctl_reg.ack;
        out_data_next.tx_byte        = staged_tx_next;
        out_data_next.tx_loaded      = s1_ctl_reg.load_mem || s1_ctl_reg.load_zero;
        out_data_next.data_ready     = s1_ctl_reg.ready;
        out_data_next.host_read_byte = s1_ctl_reg.host_read ? rx_rdata : 8'h00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recv_count_reg <= i2csb_pkg::RXC_W'(1);
            send_count_reg <= i2csb_pkg::TXC_W'(1);
            ready_flag_reg <= 1'b0;
            staged_tx_reg  <= 8'h00;
            s1_valid_reg   <= 1'b0;
            s1_ctl_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            recv_count_reg <= recv_count_next;
            send_count_reg <= send_count_next;
            ready_flag_reg <= ready_flag_next;
            if (in_ready)
            begin
                s1_valid_reg <= in_fire;
                s1_ctl_reg   <= s1_ctl_next;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
                if (s1_valid_reg)
                begin
                    staged_tx_reg <= staged_tx_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_recv_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        recv_count_reg >= i2csb_pkg::RXC_W'(1)
        && 32'(recv_count_reg) <= i2csb_pkg::RX_DEPTH)
        else $error("receive count out of range");

    a_send_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        send_count_reg >= i2csb_pkg::TXC_W'(1)
        && 32'(send_count_reg) <= i2csb_pkg::TX_DEPTH + 1)
        else $error("send count out of range");

    a_host_read_keeps_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_data.mode == i2csb_pkg::MODE_HOST_RD
        |=> ready_flag_reg == $past(ready_flag_reg))
        else $error("host read changed the ready flag");

    a_addr_resets_rx: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_data.mode == i2csb_pkg::MODE_ADDR && !in_data.arbitration_lost
        |=> recv_count_reg == i2csb_pkg::RXC_W'(1))
        else $error("address item did not reset the receive count");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_ctl_reg))
        else $error("data stage lost an item under stall");
`endif

endmodule

`default_nettype wire

### hw/rtl/i2csb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module i2csb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### sim/i2csb_result_checker.sv
// Checker that predicts each result of the I2C slave buffer handler and compares what comes out.
`timescale 1ns / 1ps

module i2csb_result_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  i2csb_pkg::in_item_t  in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  i2csb_pkg::out_item_t out_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [6:0]           cfg_data,
    output int                   mismatches,
    output int                   outstanding,
    output int                   compared
);

    logic [7:0]                  rx_image [i2csb_pkg::RX_DEPTH];
    logic [7:0]                  tx_image [i2csb_pkg::TX_DEPTH];
    logic [i2csb_pkg::RXC_W-1:0] rx_fill;
    logic [i2csb_pkg::TXC_W-1:0] tx_next;
    logic                        ready_seen;
    logic [7:0]                  staged_byte;
    logic [6:0]                  own_addr;
    i2csb_pkg::out_item_t        predicted_results [$];

    // Both buffers are sixteen deep, so every four-bit host index is in range.
    function automatic i2csb_pkg::out_item_t apply_bus_event(i2csb_pkg::in_item_t ev);
        i2csb_pkg::out_item_t res;
        res = '0;
        if (ev.mode == i2csb_pkg::MODE_HOST_WR)
        begin
            tx_image[ev.host_index] = ev.host_byte;
        end
        else if (ev.mode == i2csb_pkg::MODE_HOST_RD)
        begin
            res.host_read_byte = rx_image[ev.host_index];
        end
        else if (!ev.arbitration_lost)
        begin
            case (ev.mode)
                i2csb_pkg::MODE_ADDR:
                begin
                    rx_fill = i2csb_pkg::RXC_W'(1);
                    tx_next = i2csb_pkg::TXC_W'(1);
                    if (ev.bus_byte[7:1] == own_addr)
                    begin
                        res.ack_drive = 1'b1;
                        if (ev.bus_byte[0])
                        begin
                            staged_byte = tx_image[0];
                            tx_next = i2csb_pkg::TXC_W'(2);
                            res.tx_loaded = 1'b1;
                        end
                    end
                end
                i2csb_pkg::MODE_RX:
                begin
                    // Once the buffer is full the last slot keeps being overwritten.
                    rx_image[i2csb_pkg::RX_AW'(rx_fill - 1'b1)] = ev.bus_byte;
                    if (rx_fill < i2csb_pkg::RX_DEPTH)
                    begin
                        rx_fill++;
                        ready_seen = 1'b0;
                    end
                    else
                    begin
                        ready_seen = 1'b1;
                    end
                    res.ack_drive = 1'b1;
                end
                i2csb_pkg::MODE_SENT:
                begin
                    if (ev.master_acked)
                    begin
                        if (tx_next <= i2csb_pkg::TX_DEPTH)
                        begin
                            staged_byte = tx_image[i2csb_pkg::TX_AW'(tx_next - 1'b1)];
                            tx_next++;
                        end
                        else
                        begin
                            staged_byte = 8'h00;
                        end
                        res.tx_loaded = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        res.tx_byte    = staged_byte;
        res.data_ready = ready_seen;
        return res;
    endfunction

    task automatic compare_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        i2csb_pkg::out_item_t want;
        if (!rst_n)
        begin
            rx_fill     = i2csb_pkg::RXC_W'(1);
            tx_next     = i2csb_pkg::TXC_W'(1);
            ready_seen  = 1'b0;
            staged_byte = 8'h00;
            own_addr    = i2csb_pkg::SLAVE_ADDR_RESET;
            predicted_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                own_addr = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with nothing predicted, expected none, got %h",
                             $time, out_data);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    compared++;
                    compare_field("ack_drive", 8'(want.ack_drive), 8'(out_data.ack_drive));
                    compare_field("tx_byte", want.tx_byte, out_data.tx_byte);
                    compare_field("tx_loaded", 8'(want.tx_loaded), 8'(out_data.tx_loaded));
                    compare_field("data_ready", 8'(want.data_ready),
                                  8'(out_data.data_ready));
                    compare_field("host_read_byte", want.host_read_byte,
                                  out_data.host_read_byte);
                end
            end
            if (in_valid && in_ready)
            begin
                predicted_results.push_back(apply_bus_event(in_data));
            end
        end
        outstanding = predicted_results.size();
    end

endmodule

### sim/i2c_slave_buffer_handler_unit_tb.sv
// Testbench top that drives bus events and host accesses into the buffer handler.
`timescale 1ns / 1ps

module i2c_slave_buffer_handler_unit_tb;

    localparam logic [2:0] MODE_UNKNOWN = 3'd7;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 100;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    i2csb_pkg::in_item_t  in_data;
    logic                 out_valid;
    logic                 out_ready;
    i2csb_pkg::out_item_t out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [6:0]           cfg_data;

    int mismatches;
    int outstanding;
    int compared;

    int cycles = 0;
    int stall_tick = 0;
    int stall_style = 0;
    int burst_left = 0;
    int events_sent = 0;
    int mode_count [8];
    logic [i2csb_pkg::RX_AW-1:0]    rx_slot;
    logic [i2csb_pkg::RX_DEPTH-1:0] rx_seen;
    logic [6:0] cur_addr;
    logic [6:0] phase_addr [5];

    i2c_slave_buffer_handler_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    i2csb_result_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .compared    (compared)
    );

    always #2 clk = ~clk;

    // The result side switches between randomly chosen stall styles.
    always @(negedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 97 == 0)
        begin
            stall_style <= $urandom_range(0, 3);
        end
        case (stall_style)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom);
            2:       out_ready <= (stall_tick % 4 == 0);
            default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("i2c_slave_buffer_handler_unit_tb: done, errors");
            $finish;
        end
    end

    // Only slots that have received a byte are ever read back by the host.
    function automatic logic [3:0] written_rx_index();
        logic [3:0] idx;
        idx = 4'($urandom);
        while (!rx_seen[idx])
        begin
            idx = 4'($urandom);
        end
        return idx;
    endfunction

    function automatic i2csb_pkg::in_item_t fresh_event(logic [2:0] mode);
        i2csb_pkg::in_item_t ev;
        ev.mode             = mode;
        ev.bus_byte         = 8'($urandom);
        ev.arbitration_lost = 1'b0;
        ev.master_acked     = 1'($urandom);
        ev.host_index       = 4'($urandom);
        ev.host_byte        = 8'($urandom);
        if (mode == i2csb_pkg::MODE_HOST_RD)
        begin
            ev.host_index = written_rx_index();
        end
        return ev;
    endfunction

    function automatic i2csb_pkg::in_item_t address_event(logic rd, logic match);
        i2csb_pkg::in_item_t ev;
        ev = fresh_event(i2csb_pkg::MODE_ADDR);
        if (match)
        begin
            ev.bus_byte = {cur_addr, rd};
        end
        else
        begin
            ev.bus_byte = {cur_addr ^ 7'($urandom_range(1, 127)), rd};
        end
        return ev;
    endfunction

    function automatic i2csb_pkg::in_item_t noise_event();
        logic [2:0]          mode;
        i2csb_pkg::in_item_t ev;
        mode = 3'($urandom_range(0, 7));
        if (mode == i2csb_pkg::MODE_HOST_RD && rx_seen == '0)
        begin
            mode = i2csb_pkg::MODE_HOST_WR;
        end
        ev = fresh_event(mode);
        ev.arbitration_lost = 1'($urandom);
        return ev;
    endfunction

    function automatic int burst_length();
        if ($urandom_range(0, 3) == 0)
        begin
            return $urandom_range(15, 20);
        end
        return $urandom_range(1, 6);
    endfunction

    task automatic idle_in(int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic pace();
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 15);
            if ($urandom_range(0, 3) != 0)
            begin
                idle_in($urandom_range(1, 6));
            end
        end
    endtask

    task automatic put_event(i2csb_pkg::in_item_t ev);
        events_sent++;
        mode_count[ev.mode]++;
        if (!ev.arbitration_lost && ev.mode == i2csb_pkg::MODE_ADDR)
        begin
            rx_slot = '0;
        end
        else if (!ev.arbitration_lost && ev.mode == i2csb_pkg::MODE_RX)
        begin
            rx_seen[rx_slot] = 1'b1;
            if (rx_slot < i2csb_pkg::RX_DEPTH - 1)
            begin
                rx_slot++;
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= ev;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        pace();
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_address(logic [6:0] addr);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= addr;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_addr = addr;
    endtask

    // Mostly well-formed write and read transfers, with stray events mixed in.
    task automatic run_traffic(int quota);
        int                  stop_at;
        int                  n;
        int                  choice;
        i2csb_pkg::in_item_t ev;
        stop_at = events_sent + quota;
        while (events_sent < stop_at)
        begin
            choice = $urandom_range(0, 99);
            if (choice < 75)
            begin
                put_event(address_event(choice >= 40, $urandom_range(0, 19) != 0));
                n = burst_length();
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 19) == 0)
                    begin
                        put_event(noise_event());
                    end
                    if (choice < 40)
                    begin
                        ev = fresh_event(i2csb_pkg::MODE_RX);
                    end
                    else
                    begin
                        ev = fresh_event(i2csb_pkg::MODE_SENT);
                        ev.master_acked = ($urandom_range(0, 7) != 0);
                    end
                    put_event(ev);
                end
                if ($urandom_range(0, 4) != 0)
                begin
                    put_event(fresh_event(i2csb_pkg::MODE_STOP));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 3)) put_event(noise_event());
            end
        end
    endtask

    initial
    begin
        i2csb_pkg::in_item_t ev;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        rx_seen   = '0;
        rx_slot   = '0;
        cur_addr  = i2csb_pkg::SLAVE_ADDR_RESET;
        foreach (mode_count[i])
        begin
            mode_count[i] = 0;
        end
        phase_addr[0] = 7'h00;
        phase_addr[1] = 7'h7F;
        phase_addr[2] = 7'($urandom);
        phase_addr[3] = i2csb_pkg::SLAVE_ADDR_RESET;
        phase_addr[4] = 7'($urandom);
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Fill the whole transmit buffer first so every later fetch finds written data.
        for (int i = 0; i < i2csb_pkg::TX_DEPTH; i++)
        begin
            ev = fresh_event(i2csb_pkg::MODE_HOST_WR);
            ev.host_index = 4'(i);
            if (i == 0)
            begin
                ev.host_byte = 8'h00;
            end
            else if (i == i2csb_pkg::TX_DEPTH - 1)
            begin
                ev.host_byte = 8'hFF;
            end
            put_event(ev);
        end
        put_event(address_event(1'b0, 1'b1));
        ev = fresh_event(i2csb_pkg::MODE_RX);
        ev.bus_byte = 8'h00;
        put_event(ev);
        ev.bus_byte = 8'hFF;
        put_event(ev);
        ev = fresh_event(i2csb_pkg::MODE_HOST_RD);
        ev.host_index = 4'd1;
        put_event(ev);
        // A host read ignores arbitration loss.
        ev.host_index = 4'd0;
        ev.arbitration_lost = 1'b1;
        put_event(ev);
        put_event(address_event(1'b1, 1'b0));
        put_event(address_event(1'b1, 1'b1));
        ev = fresh_event(i2csb_pkg::MODE_SENT);
        ev.master_acked = 1'b1;
        put_event(ev);
        ev.master_acked = 1'b0;
        put_event(ev);
        ev.master_acked = 1'b1;
        put_event(ev);
        ev.arbitration_lost = 1'b1;
        put_event(ev);
        ev = address_event(1'b1, 1'b1);
        ev.arbitration_lost = 1'b1;
        put_event(ev);
        ev = fresh_event(i2csb_pkg::MODE_RX);
        ev.arbitration_lost = 1'b1;
        put_event(ev);
        put_event(fresh_event(i2csb_pkg::MODE_STOP));
        put_event(fresh_event(i2csb_pkg::MODE_ERR));
        put_event(fresh_event(MODE_UNKNOWN));

        foreach (phase_addr[p])
        begin
            drain();
            write_address(phase_addr[p]);
            if (p == 2)
            begin
                run_traffic(PHASE_ITEMS / 2);
                drain();
                run_traffic(PHASE_ITEMS - PHASE_ITEMS / 2);
            end
            else
            begin
                run_traffic(PHASE_ITEMS);
            end
        end
        drain();
        repeat (8) @(negedge clk);

        $display("Ran %0d events through five address settings: %0d address, %0d rx, %0d sent,",
                 events_sent, mode_count[i2csb_pkg::MODE_ADDR],
                 mode_count[i2csb_pkg::MODE_RX], mode_count[i2csb_pkg::MODE_SENT]);
        $display("%0d stop, %0d error, %0d unknown, %0d host writes, %0d host reads; %0d checked",
                 mode_count[i2csb_pkg::MODE_STOP], mode_count[i2csb_pkg::MODE_ERR],
                 mode_count[MODE_UNKNOWN], mode_count[i2csb_pkg::MODE_HOST_WR],
                 mode_count[i2csb_pkg::MODE_HOST_RD], compared);
        if (mismatches == 0)
        begin
            $display("i2c_slave_buffer_handler_unit_tb: done, clean");
        end
        else
        begin
            $display("i2c_slave_buffer_handler_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/i2csb_pkg.sv
hw/rtl/i2csb_ram.sv
hw/rtl/i2c_slave_buffer_handler_unit.sv
sim/i2csb_result_checker.sv
sim/i2c_slave_buffer_handler_unit_tb.sv
